FILE: rtl/core/lfu_pkg.sv
// Shared types and constants for the LFU key/value store.
// Used by lfu_store, lfu_scan and lfu_cache_key_value; no dependencies.
package lfu_pkg;

    localparam int KEY_W      = 32;
    localparam int VALUE_W    = 32;
    localparam int STAMP_W    = 48;
    localparam int LIMIT_W    = 5;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    localparam logic [LIMIT_W-1:0]        LIMIT_RESET = 5'd16;
    localparam logic signed [VALUE_W-1:0] MISS_VALUE  = -32'sd1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic signed [KEY_W-1:0]  lookup_key;
        logic signed [VALUE_W-1:0] store_value;
    } lfu_in_t;

    typedef struct packed {
        logic                      hit;
        logic signed [VALUE_W-1:0] read_value;
    } lfu_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_EMIT
    } lfu_state_t;

    typedef struct packed {
        logic en;
        logic set_key;
        logic set_value;
    } lfu_wr_ctl_t;

    typedef struct packed {
        logic clear;
        logic sample;
    } lfu_scan_ctl_t;

endpackage

FILE: rtl/core/lfu_store.sv
// Entry storage: key, value, use count and stamp memories plus valid bits.
// One write port, one registered read port. Depends on lfu_pkg.
module lfu_store #(
    parameter int ENTRIES  = 16,
    parameter int USE_BITS = 16,
    parameter int IDX_W    = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [IDX_W-1:0]             rd_idx,
    input  lfu_pkg::lfu_wr_ctl_t         wr,
    input  logic [IDX_W-1:0]             wr_idx,
    input  logic [lfu_pkg::KEY_W-1:0]    wr_key,
    input  logic [lfu_pkg::VALUE_W-1:0]  wr_value,
    input  logic [USE_BITS-1:0]          wr_uses,
    input  logic [lfu_pkg::STAMP_W-1:0]  wr_stamp,
    output logic                         rd_valid,
    output logic [lfu_pkg::KEY_W-1:0]    rd_key,
    output logic [lfu_pkg::VALUE_W-1:0]  rd_value,
    output logic [USE_BITS-1:0]          rd_uses,
    output logic [lfu_pkg::STAMP_W-1:0]  rd_stamp
);
    import lfu_pkg::*;

    logic [KEY_W-1:0]    key_mem_reg   [ENTRIES];
    logic [VALUE_W-1:0]  value_mem_reg [ENTRIES];
    logic [USE_BITS-1:0] uses_mem_reg  [ENTRIES];
    logic [STAMP_W-1:0]  stamp_mem_reg [ENTRIES];
    logic [ENTRIES-1:0]  valid_reg;

    logic                rd_valid_reg;
    logic [KEY_W-1:0]    rd_key_reg;
    logic [VALUE_W-1:0]  rd_value_reg;
    logic [USE_BITS-1:0] rd_uses_reg;
    logic [STAMP_W-1:0]  rd_stamp_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            if (wr.set_key) begin
                key_mem_reg[wr_idx] <= wr_key;
            end
            if (wr.set_value) begin
                value_mem_reg[wr_idx] <= wr_value;
            end
            uses_mem_reg[wr_idx]  <= wr_uses;
            stamp_mem_reg[wr_idx] <= wr_stamp;
        end
        if (rd_en) begin
            rd_key_reg   <= key_mem_reg[rd_idx];
            rd_value_reg <= value_mem_reg[rd_idx];
            rd_uses_reg  <= uses_mem_reg[rd_idx];
            rd_stamp_reg <= stamp_mem_reg[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en && wr.set_key) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;
    assign rd_uses  = rd_uses_reg;
    assign rd_stamp = rd_stamp_reg;

endmodule

FILE: rtl/core/lfu_scan.sv
// Shared compare unit: takes one entry per cycle and tracks the first key
// match, the first free slot and the eviction victim. Depends on lfu_pkg.
module lfu_scan #(
    parameter int USE_BITS = 16,
    parameter int IDX_W    = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lfu_pkg::lfu_scan_ctl_t       ctl,
    input  logic [lfu_pkg::KEY_W-1:0]    key,
    input  logic [IDX_W-1:0]             ent_idx,
    input  logic                         ent_valid,
    input  logic [lfu_pkg::KEY_W-1:0]    ent_key,
    input  logic [lfu_pkg::VALUE_W-1:0]  ent_value,
    input  logic [USE_BITS-1:0]          ent_uses,
    input  logic [lfu_pkg::STAMP_W-1:0]  ent_stamp,
    output logic                         match_found,
    output logic [IDX_W-1:0]             match_idx,
    output logic [lfu_pkg::VALUE_W-1:0]  match_value,
    output logic [USE_BITS-1:0]          match_uses,
    output logic                         free_found,
    output logic [IDX_W-1:0]             free_idx,
    output logic [IDX_W-1:0]             min_idx
);
    import lfu_pkg::*;

    logic                match_found_reg;
    logic [IDX_W-1:0]    match_idx_reg;
    logic [VALUE_W-1:0]  match_value_reg;
    logic [USE_BITS-1:0] match_uses_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic                min_found_reg;
    logic [IDX_W-1:0]    min_idx_reg;
    logic [USE_BITS-1:0] min_uses_reg;
    logic [STAMP_W-1:0]  min_stamp_reg;

    logic is_match;
    logic is_free;
    logic is_lower;

    always_comb begin
        is_match = ctl.sample && ent_valid && (ent_key == key) && !match_found_reg;
        is_free  = ctl.sample && !ent_valid && !free_found_reg;
        is_lower = ctl.sample && ent_valid &&
                   (!min_found_reg || (ent_uses < min_uses_reg) ||
                    ((ent_uses == min_uses_reg) && (ent_stamp < min_stamp_reg)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            min_found_reg   <= 1'b0;
        end else if (ctl.clear) begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            min_found_reg   <= 1'b0;
        end else begin
            if (is_match) begin
                match_found_reg <= 1'b1;
            end
            if (is_free) begin
                free_found_reg <= 1'b1;
            end
            if (is_lower) begin
                min_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (is_match) begin
            match_idx_reg   <= ent_idx;
            match_value_reg <= ent_value;
            match_uses_reg  <= ent_uses;
        end
        if (is_free) begin
            free_idx_reg <= ent_idx;
        end
        if (is_lower) begin
            min_idx_reg   <= ent_idx;
            min_uses_reg  <= ent_uses;
            min_stamp_reg <= ent_stamp;
        end
    end

    assign match_found = match_found_reg;
    assign match_idx   = match_idx_reg;
    assign match_value = match_value_reg;
    assign match_uses  = match_uses_reg;
    assign free_found  = free_found_reg;
    assign free_idx    = free_idx_reg;
    assign min_idx     = min_idx_reg;

endmodule

FILE: rtl/core/lfu_cache_key_value.sv
// LFU key/value store, top level: APB register, sequencer, output register.
// Depends on lfu_pkg, lfu_store and lfu_scan.
//
// Usage:
//   s_ channel carries get (kind 0) or put (kind 1) items; m_ channel returns
//   one result item per get (hit flag and value, -1 on a miss), none per put.
//   APB register 0 (entry_limit) sets the number of active slots, reset 16;
//   values above ENTRIES act as ENTRIES, zero disables the store.
//
// Sequencing (n = active slots):
//   Each item reads the n active entries through one compare unit, one entry
//   per cycle, then drains the read and compare registers, then passes through
//   the write state. A get result is registered in the emit state, and s_ready
//   returns in that same cycle. One item is in work at a time.
//   A stalled result sits in the output register; the block keeps working
//   on the next item and holds the following result until the slot frees.
//
// Reset: synchronous, active low. Clears the valid map, the access clock,
//   the sequencer and the output register, and sets entry_limit to 16.
module lfu_cache_key_value #(
    parameter int ENTRIES  = 16,
    parameter int USE_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lfu_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lfu_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lfu_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  lfu_pkg::lfu_in_t                 s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output lfu_pkg::lfu_out_t                m_item
);
    import lfu_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    lfu_state_t          state_reg, state_next;
    logic [LIMIT_W-1:0]  limit_reg;
    lfu_in_t             item_reg;
    logic [CNT_W-1:0]    active_reg, active_next;
    logic [CNT_W-1:0]    rd_cnt_reg;
    logic                sample_reg;
    logic [IDX_W-1:0]    sample_idx_reg;
    logic [STAMP_W-1:0]  clock_reg;
    logic                m_valid_reg;
    lfu_out_t            m_item_reg;

    logic                accept;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_idx;
    logic                out_free;
    logic [CMP_W-1:0]    limit_ext;

    lfu_wr_ctl_t         wr;
    lfu_scan_ctl_t       scan_ctl;
    logic [IDX_W-1:0]    wr_idx;
    logic [USE_BITS-1:0] wr_uses;
    logic                do_insert;
    logic                emit_load;

    logic                ent_valid;
    logic [KEY_W-1:0]    ent_key;
    logic [VALUE_W-1:0]  ent_value;
    logic [USE_BITS-1:0] ent_uses;
    logic [STAMP_W-1:0]  ent_stamp;

    logic                match_found;
    logic [IDX_W-1:0]    match_idx;
    logic [VALUE_W-1:0]  match_value;
    logic [USE_BITS-1:0] match_uses;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic [IDX_W-1:0]    min_idx;

    // configuration port
    assign pready = 1'b1;
    assign prdata = APB_DATA_W'(limit_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb begin
        limit_ext   = CMP_W'(limit_reg);
        active_next = (limit_ext > CMP_W'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(limit_ext);
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign rd_en    = (state_reg == ST_SCAN) && (rd_cnt_reg < active_reg);
    assign rd_idx   = rd_cnt_reg[IDX_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!rd_en && !sample_reg) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = (item_reg.kind == OP_GET) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        scan_ctl.clear  = accept;
        scan_ctl.sample = sample_reg;
        do_insert       = (item_reg.kind == OP_PUT) && (active_reg != '0) && !match_found;
        wr              = '0;
        emit_load       = 1'b0;
        unique case (state_reg)
            ST_WRITE: begin
                wr.en        = match_found || do_insert;
                wr.set_key   = do_insert;
                wr.set_value = (item_reg.kind == OP_PUT) && (active_reg != '0);
            end
            ST_EMIT: begin
                emit_load = out_free;
            end
            default: begin
                wr = '0;
            end
        endcase
        if (match_found) begin
            wr_idx = match_idx;
        end else if (free_found) begin
            wr_idx = free_idx;
        end else begin
            wr_idx = min_idx;
        end
        if (do_insert) begin
            wr_uses = USE_BITS'(1);
        end else if (&match_uses) begin
            wr_uses = match_uses;
        end else begin
            wr_uses = match_uses + USE_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_cnt_reg  <= '0;
            sample_reg  <= 1'b0;
            clock_reg   <= '0;
            m_valid_reg <= 1'b0;
            active_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            sample_reg <= rd_en;
            if (accept) begin
                rd_cnt_reg <= '0;
                active_reg <= active_next;
            end else if (rd_en) begin
                rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
            end
            if (wr.en) begin
                clock_reg <= clock_reg + STAMP_W'(1);
            end
            if (emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
        if (rd_en) begin
            sample_idx_reg <= rd_idx;
        end
        if (emit_load) begin
            m_item_reg.hit        <= match_found;
            m_item_reg.read_value <= match_found ? match_value : MISS_VALUE;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    lfu_store #(
        .ENTRIES  (ENTRIES),
        .USE_BITS (USE_BITS),
        .IDX_W    (IDX_W)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .wr       (wr),
        .wr_idx   (wr_idx),
        .wr_key   (item_reg.lookup_key),
        .wr_value (item_reg.store_value),
        .wr_uses  (wr_uses),
        .wr_stamp (clock_reg),
        .rd_valid (ent_valid),
        .rd_key   (ent_key),
        .rd_value (ent_value),
        .rd_uses  (ent_uses),
        .rd_stamp (ent_stamp)
    );

    lfu_scan #(
        .USE_BITS (USE_BITS),
        .IDX_W    (IDX_W)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (scan_ctl),
        .key         (item_reg.lookup_key),
        .ent_idx     (sample_idx_reg),
        .ent_valid   (ent_valid),
        .ent_key     (ent_key),
        .ent_value   (ent_value),
        .ent_uses    (ent_uses),
        .ent_stamp   (ent_stamp),
        .match_found (match_found),
        .match_idx   (match_idx),
        .match_value (match_value),
        .match_uses  (match_uses),
        .free_found  (free_found),
        .free_idx    (free_idx),
        .min_idx     (min_idx)
    );

`ifndef SYNTHESIS
    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result item loaded outside emit state");

    a_clock_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (clock_reg != $past(clock_reg)) |-> $past(state_reg) == ST_WRITE)
        else $error("access clock moved outside write cycle");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (rd_cnt_reg <= active_reg))
        else $error("scan counter past active slots");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for lfu_cache_key_value: LFU get/put traffic with an
// in-bench LFU mirror, APB limit changes and random stalls on both channels.
// Depends on lfu_pkg and the RTL of lfu_cache_key_value.
`timescale 1ns / 100ps

module tb_top;
    import lfu_pkg::*;

    localparam int SLOTS         = 16;
    localparam int USE_W         = 16;
    localparam int POOL_SIZE     = SLOTS + 6;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOT_TOUCHES   = 20;
    localparam int MAX_REPORTS   = 40;

    localparam logic [APB_ADDR_W-1:0] ADDR_ENTRY_LIMIT = '0;

    localparam logic signed [KEY_W-1:0] SAT_KEY   = 32'sh5A5A_0001;
    localparam logic signed [KEY_W-1:0] RIVAL_KEY = 32'sh5A5A_0002;
    localparam logic signed [KEY_W-1:0] LATE_KEY  = 32'sh5A5A_0003;

    class lfu_mirror;
        bit                        valid  [SLOTS];
        logic signed [KEY_W-1:0]   keys   [SLOTS];
        logic signed [VALUE_W-1:0] values [SLOTS];
        bit [USE_W-1:0]            uses   [SLOTS];
        bit [STAMP_W-1:0]          stamps [SLOTS];
        bit [STAMP_W-1:0]          tick;
        bit [LIMIT_W-1:0]          limit;
        lfu_out_t                  pending_reads [$];
        int mismatches, gets, hits, puts, evictions;

        function new();
            for (int i = 0; i < SLOTS; i++) valid[i] = 1'b0;
            tick  = '0;
            limit = LIMIT_RESET;
        endfunction

        function void set_limit(bit [LIMIT_W-1:0] v);
            limit = v;
        endfunction

        function void bump(int i);
            if (uses[i] != {USE_W{1'b1}}) uses[i] = uses[i] + 1'b1;
            stamps[i] = tick;
            tick      = tick + 1'b1;
        endfunction

        function int victim(int n);
            int best;
            best = 0;
            for (int i = 0; i < n; i++)
                if (!valid[i]) return i;
            for (int i = 1; i < n; i++)
                if (uses[i] < uses[best] ||
                    (uses[i] == uses[best] && stamps[i] < stamps[best]))
                    best = i;
            evictions++;
            return best;
        endfunction

        function void take_request(lfu_in_t it);
            int n, at, s;
            lfu_out_t want;
            n  = (limit > SLOTS) ? SLOTS : int'(limit);
            at = -1;
            for (int i = 0; i < n; i++)
                if (at < 0 && valid[i] && keys[i] == it.lookup_key) at = i;
            if (it.kind == OP_GET) begin
                gets++;
                if (at < 0) begin
                    want.hit        = 1'b0;
                    want.read_value = MISS_VALUE;
                end else begin
                    hits++;
                    bump(at);
                    want.hit        = 1'b1;
                    want.read_value = values[at];
                end
                pending_reads.push_back(want);
            end else begin
                puts++;
                if (n == 0) return;
                if (at >= 0) begin
                    values[at] = it.store_value;
                    bump(at);
                end else begin
                    s         = victim(n);
                    valid[s]  = 1'b1;
                    keys[s]   = it.lookup_key;
                    values[s] = it.store_value;
                    uses[s]   = USE_W'(1);
                    stamps[s] = tick;
                    tick      = tick + 1'b1;
                end
            end
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_read(lfu_out_t got);
            lfu_out_t want;
            if (pending_reads.size() == 0) begin
                report($sformatf("result hit=%0b value=%0d with no get pending",
                                 got.hit, got.read_value));
                return;
            end
            want = pending_reads.pop_front();
            if (got.hit !== want.hit)
                report($sformatf("hit %0b, expected %0b", got.hit, want.hit));
            if (got.read_value !== want.read_value)
                report($sformatf("read_value %0d, expected %0d",
                                 got.read_value, want.read_value));
        endtask
    endclass

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    lfu_in_t               s_item  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    lfu_out_t              m_item;

    lfu_mirror mirror = new();
    bit        quiet  = 1'b0;
    int        limit_changes = 0;
    logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

    lfu_cache_key_value dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) mirror.check_read(m_item);
            if (s_valid && s_ready) mirror.take_request(s_item);
        end
    end

    always @(posedge aclk) begin
        int idle;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle = 0;
        else
            idle++;
        if (idle >= STALL_LIMIT) begin
            $display("timeout: no activity for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        int n;
        do @(posedge aclk); while (!aresetn);
        forever begin
            m_ready <= 1'b1;
            n = $urandom_range(1, 8);
            repeat (n) @(posedge aclk);
            n = pick_gap();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    task automatic push_item(input lfu_in_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send(input logic kind, input logic signed [KEY_W-1:0] key,
                        input logic signed [VALUE_W-1:0] value);
        lfu_in_t it;
        it.kind        = kind;
        it.lookup_key  = key;
        it.store_value = value;
        push_item(it);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (mirror.pending_reads.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic read_limit(input logic [LIMIT_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ENTRY_LIMIT;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DATA_W'(want))
            mirror.report($sformatf("entry_limit reads %0d, expected %0d", prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_limit(input logic [LIMIT_W-1:0] lim);
        logic [APB_DATA_W-1:0] word;
        settle();
        word          = $urandom();
        word[LIMIT_W-1:0] = lim;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ENTRY_LIMIT;
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        mirror.set_limit(lim);
        limit_changes++;
        @(posedge aclk);
        read_limit(lim);
    endtask

    function automatic lfu_in_t random_item();
        lfu_in_t it;
        int span;
        span = ((mirror.limit > SLOTS) ? SLOTS : int'(mirror.limit)) + 6;
        it.kind = ($urandom_range(0, 99) < 45) ? OP_PUT : OP_GET;
        if ($urandom_range(0, 9) == 0)
            it.lookup_key = $urandom();
        else
            it.lookup_key = key_pool[$urandom_range(0, span - 1)];
        case ($urandom_range(0, 15))
            0:       it.store_value = 32'sh8000_0000;
            1:       it.store_value = 32'sh7FFF_FFFF;
            default: it.store_value = $urandom();
        endcase
        return it;
    endfunction

    initial begin
        logic [LIMIT_W-1:0] plan [10];

        plan = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd8, 5'd17, 5'd3, 5'd16, 5'd5, 5'd2};
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7FFF_FFFF;
        key_pool[2] = 32'sh0000_0000;
        key_pool[3] = -32'sd1;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_limit(LIMIT_RESET);

        // directed: extremes, update, eviction by count, eviction tie by age
        send(OP_GET, 32'sh0000_0000, 32'sh0);
        apply_limit(5'd4);
        send(OP_PUT, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send(OP_PUT, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send(OP_PUT, 32'sh0000_0000, 32'sh0000_0000);
        send(OP_PUT, -32'sd1,        -32'sd1);
        send(OP_GET, 32'sh7FFF_FFFF, 32'sh0);
        send(OP_GET, 32'sh8000_0000, 32'sh0);
        send(OP_GET, 32'sh0000_0000, 32'sh0);
        send(OP_GET, 32'sh0000_0000, 32'sh0);
        send(OP_PUT, 32'sh8000_0000, 32'sh5);
        send(OP_PUT, 32'sh0000_0007, 32'sh7);
        send(OP_PUT, 32'sh0000_0008, 32'sh8);
        send(OP_GET, -32'sd1,        32'sh0);
        send(OP_GET, 32'sh0000_0007, 32'sh0);
        send(OP_GET, 32'sh0000_0008, 32'sh0);
        send(OP_PUT, 32'sh0000_0009, 32'sh9);
        send(OP_GET, 32'sh7FFF_FFFF, 32'sh0);
        send(OP_GET, 32'sh8000_0000, 32'sh0);

        // heat one entry alone, then make it compete with a fresher one
        quiet = 1'b1;
        apply_limit(5'd1);
        send(OP_PUT, SAT_KEY, 32'sh1234_5678);
        for (int i = 0; i < HOT_TOUCHES; i++) send(OP_GET, SAT_KEY, 32'sh0);
        apply_limit(5'd2);
        send(OP_PUT, RIVAL_KEY, 32'sh0BAD_F00D);
        for (int i = 0; i < 10; i++) send(OP_GET, RIVAL_KEY, 32'sh0);
        send(OP_PUT, LATE_KEY, 32'sh0000_0042);
        send(OP_GET, SAT_KEY, 32'sh0);
        send(OP_GET, RIVAL_KEY, 32'sh0);
        send(OP_GET, LATE_KEY, 32'sh0);
        quiet = 1'b0;

        foreach (plan[p]) begin
            apply_limit(plan[p]);
            quiet = ($urandom_range(0, 3) == 0);
            repeat ((plan[p] == 0) ? 30 : 60) push_item(random_item());
        end
        quiet = 1'b0;

        settle();
        $display("covered %0d gets (%0d hits), %0d puts, %0d evictions, %0d limit writes",
                 mirror.gets, mirror.hits, mirror.puts, mirror.evictions, limit_changes);
        $display("included a hot entry racing a fresher one and limits from 0 to 31");
        if (mirror.mismatches == 0 && mirror.pending_reads.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
